// ===== rtl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the address-resolution cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int LIFE_W      = 16;
	localparam int MAXL_W      = 15;
	localparam int CMD_W       = 2;
	localparam int ENTRIES_DEF = 8;

	localparam logic [MAXL_W-1:0]        MAX_LIFETIME_RST = 15'd300;
	localparam logic signed [LIFE_W-1:0] NEVER_FILLED     = -16'sd258;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;

	// word handed from one cell to the next during a scan
	typedef struct packed {
		logic                     hit;
		logic [MAC_W-1:0]         mac;
		logic signed [LIFE_W-1:0] lowest;
	} carry_t;

	// what the cells compare against during a scan
	typedef struct packed {
		logic            insert;
		logic [IP_W-1:0] ip;
	} key_t;

	// update broadcast to the addressed cell at the end of an item
	typedef struct packed {
		logic             life_en;
		logic             data_en;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
	} wr_t;

endpackage

`default_nettype wire

// ===== rtl/arp_cell.sv =====
// ----------------------------------------------------------------------------
// arp_cell
// One cache slot: holds IP, MAC and lifetime, and does one hop of the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cell #(
	parameter int IDXW = $clog2(arp_pkg::ENTRIES_DEF),
	parameter int IDX  = 0
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [arp_pkg::MAXL_W-1:0]  max_lifetime,
	input  wire arp_pkg::key_t               key,
	input  wire arp_pkg::carry_t             carry_in,
	input  wire logic [IDXW-1:0]             idx_in,
	output arp_pkg::carry_t                  carry_out,
	output logic [IDXW-1:0]                  idx_out,
	input  wire logic                        tick,
	input  wire arp_pkg::wr_t                wr,
	input  wire logic [IDXW-1:0]             wr_idx
);
	import arp_pkg::*;

	localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

	logic signed [LIFE_W-1:0] life_q;
	logic [IP_W-1:0]          ip_q;
	logic [MAC_W-1:0]         mac_q;
	carry_t                   carry_q;
	logic [IDXW-1:0]          idx_q;
	carry_t                   carry_d;
	logic [IDXW-1:0]          idx_d;
	logic                     live;
	logic                     sel;

	assign live = (life_q > 16'sd0);
	assign sel  = (wr_idx == MY_IDX);

	// lifetime: aging on tick, refresh or fill from the broadcast
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= NEVER_FILLED;
		end else begin
			priority if (tick) begin
				if (live) life_q <= life_q - 16'sd1;
			end else if (wr.life_en && sel) begin
				life_q <= $signed({1'b0, max_lifetime});
			end
		end
	end

	// slot payload, undefined until first insert
	always_ff @(posedge clk) begin
		if (wr.data_en && sel) begin
			ip_q  <= wr.ip;
			mac_q <= wr.mac;
		end
	end

	// one scan hop: first live match for lookup, strict minimum for insert
	always_comb begin
		carry_d = carry_in;
		idx_d   = idx_in;
		if (key.insert) begin
			if (life_q < carry_in.lowest) begin
				carry_d.lowest = life_q;
				idx_d          = MY_IDX;
			end
		end else if (!carry_in.hit && live && ip_q == key.ip) begin
			carry_d.hit = 1'b1;
			carry_d.mac = mac_q;
			idx_d       = MY_IDX;
		end
	end

	always_ff @(posedge clk) begin
		carry_q <= carry_d;
		idx_q   <= idx_d;
	end

	assign carry_out = carry_q;
	assign idx_out   = idx_q;

endmodule

`default_nettype wire

// ===== rtl/arp_cache_ttl_table_core.sv =====
// ----------------------------------------------------------------------------
// arp_cache_ttl_table_core
// IPv4-to-MAC cache with per-slot lifetimes, built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Lookup and insert: the result is set by the scan word walking one cell per
//   cycle from the top slot down to slot 0.
// Tick and unused codes skip the scan. One item is in work at a time; the next
//   word is taken as soon as the previous result sits in the output register.
// Reset: lifetimes go to the never-filled value and max_lifetime to 300 at
//   once; slot addresses stay undefined until written, no clearing pass.
`default_nettype none

module arp_cache_ttl_table_core #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config write: max_lifetime
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [arp_pkg::MAXL_W-1:0]  cfg_data,
	// input words
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [79:0]                 s_tdata,  // target_ip[31:0], peer_mac[79:32]
	input  wire logic [1:0]                  s_tuser,  // command[1:0]
	// result words
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [79:0]                      m_tdata,  // resolved_mac[47:0], request_ip[79:48]
	output logic [1:0]                       m_tuser   // hit[0], send_request[1]
);
	import arp_pkg::*;

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDXW-1:0] TOP_IDX = IDXW'(ENTRIES - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

	state_t            state_q;
	logic [IDXW-1:0]   cnt_q;
	logic [MAXL_W-1:0] max_lifetime_q;
	logic [CMD_W-1:0]  cmd_q;
	key_t              key_q;
	logic [MAC_W-1:0]  mac_q;

	carry_t            chain_c   [ENTRIES+1];
	logic [IDXW-1:0]   chain_idx [ENTRIES+1];

	logic              accept;
	logic              tick;
	logic              out_free;
	logic              finish;
	wr_t               wr;
	logic              res_hit;
	logic              res_req;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign tick      = accept && (s_tuser == CMD_TICK);
	assign out_free  = !m_tvalid || m_tready;
	assign finish    = (state_q == ST_FIN) && out_free;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lifetime_q <= MAX_LIFETIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_lifetime_q <= cfg_data;
		end
	end

	// scan word entering the top cell
	assign chain_c[ENTRIES]   = '{hit: 1'b0, mac: '0,
	                              lowest: $signed({1'b0, max_lifetime_q})};
	assign chain_idx[ENTRIES] = TOP_IDX;

	// chain of slot cells, top index first
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		arp_cell #(
			.IDXW (IDXW),
			.IDX  (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.max_lifetime (max_lifetime_q),
			.key          (key_q),
			.carry_in     (chain_c[g+1]),
			.idx_in       (chain_idx[g+1]),
			.carry_out    (chain_c[g]),
			.idx_out      (chain_idx[g]),
			.tick         (tick),
			.wr           (wr),
			.wr_idx       (chain_idx[0])
		);
	end

	// result of the finished scan
	assign res_hit = (cmd_q == CMD_LOOKUP) && chain_c[0].hit;
	assign res_req = (cmd_q == CMD_LOOKUP) && !chain_c[0].hit;

	// slot update: refresh on hit, fill on insert
	always_comb begin
		wr.life_en = finish && (res_hit || cmd_q == CMD_INSERT);
		wr.data_en = finish && (cmd_q == CMD_INSERT);
		wr.ip      = key_q.ip;
		wr.mac     = mac_q;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= '0;
			cmd_q    <= CMD_TICK;
			key_q    <= '0;
			mac_q    <= '0;
		end else begin
			if (m_tvalid && m_tready && !finish) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= s_tuser;
						key_q.insert <= (s_tuser == CMD_INSERT);
						key_q.ip     <= s_tdata[31:0];
						mac_q        <= s_tdata[79:32];
						cnt_q        <= '0;
						if (s_tuser == CMD_LOOKUP || s_tuser == CMD_INSERT) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == TOP_IDX) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid       <= 1'b1;
						m_tuser        <= {res_req, res_hit};
						m_tdata[47:0]  <= res_hit ? chain_c[0].mac : '0;
						m_tdata[79:48] <= res_req ? key_q.ip : '0;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_hit_xor_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit and request raised together");

	a_hit_no_ip: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[79:48] == '0))
		else $error("request_ip set on a hit");

	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cnt_q == TOP_IDX) |=> (state_q == ST_FIN))
		else $error("scan did not end after the last cell");

	a_no_tick_at_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.life_en |-> !tick)
		else $error("slot update and tick in the same cycle");

endmodule

`default_nettype wire
